// File: rtl/core/battery_load_switch_controller_defines.svh
//------------------------------------------------------------------------------
// Battery load switch controller assertion macros
// Shared concurrent assertion forms used by the controller top level.
//------------------------------------------------------------------------------
`ifndef BATTERY_LOAD_SWITCH_CONTROLLER_DEFINES_SVH
`define BATTERY_LOAD_SWITCH_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BLSC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("blsc same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define BLSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("blsc next-cycle check failed");

`endif

// File: rtl/core/blsc_pkg.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// Battery load switch controller package
// Word types, configuration set, operation, mode and register codes.
//------------------------------------------------------------------------------
package blsc_pkg;

   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   // register indexes (byte address / 4)
   localparam logic [2:0] REG_POWER_OFF_MV          = 3'd0;
   localparam logic [2:0] REG_POWER_ON_MV           = 3'd1;
   localparam logic [2:0] REG_BAD_BATTERY_MV        = 3'd2;
   localparam logic [2:0] REG_DAY_RESTART_HYST_MV   = 3'd3;
   localparam logic [2:0] REG_LOW_BATT_CHARGE_TICKS = 3'd4;
   localparam logic [2:0] REG_WARN_TICKS            = 3'd5;
   localparam logic [2:0] REG_LOW_POWER_TICKS       = 3'd6;
   localparam logic [2:0] REG_DEFAULT_WD_OFF_TICKS  = 3'd7;

   // register reset values
   localparam logic [14:0] RST_POWER_OFF_MV          = 15'd11500;
   localparam logic [14:0] RST_POWER_ON_MV           = 15'd12500;
   localparam logic [14:0] RST_BAD_BATTERY_MV        = 15'd9000;
   localparam logic [12:0] RST_DAY_RESTART_HYST_MV   = 13'd500;
   localparam logic [15:0] RST_LOW_BATT_CHARGE_TICKS = 16'd3600;
   localparam logic [15:0] RST_WARN_TICKS            = 16'd60;
   localparam logic [15:0] RST_LOW_POWER_TICKS       = 16'd10;
   localparam logic [15:0] RST_DEFAULT_WD_OFF_TICKS  = 16'd10;

   // operation codes
   localparam logic [2:0] OP_TICK        = 3'd0;
   localparam logic [2:0] OP_INIT        = 3'd1;
   localparam logic [2:0] OP_WD_ENABLE   = 3'd2;
   localparam logic [2:0] OP_WD_TIMEOUT  = 3'd3;
   localparam logic [2:0] OP_WD_OFF_TIME = 3'd4;

   // charger states
   localparam logic [1:0] CHG_IDLE  = 2'd1;
   localparam logic [1:0] CHG_NIGHT = 2'd2;

   // reported mode codes
   localparam logic [2:0] MODE_CODE_ON        = 3'd0;
   localparam logic [2:0] MODE_CODE_ALERT_LB  = 3'd1;
   localparam logic [2:0] MODE_CODE_OFF_LB    = 3'd2;
   localparam logic [2:0] MODE_CODE_ALERT_DAY = 3'd3;
   localparam logic [2:0] MODE_CODE_OFF_DAY   = 3'd4;
   localparam logic [2:0] MODE_CODE_WD_ALERT  = 3'd5;
   localparam logic [2:0] MODE_CODE_WD_OFF    = 3'd6;
   localparam logic [2:0] MODE_CODE_UNKNOWN   = 3'd7;

   typedef enum logic [7:0] {
      MODE_ON        = 8'b0000_0001,
      MODE_ALERT_LB  = 8'b0000_0010,
      MODE_OFF_LB    = 8'b0000_0100,
      MODE_ALERT_DAY = 8'b0000_1000,
      MODE_OFF_DAY   = 8'b0001_0000,
      MODE_WD_ALERT  = 8'b0010_0000,
      MODE_WD_OFF    = 8'b0100_0000,
      MODE_UNKNOWN   = 8'b1000_0000
   } mode_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [15:0] battery_mv;
      logic [1:0]  charger_mode;
      logic        pctrl_pin;
      logic [15:0] write_value;
   } req_type;

   typedef struct packed {
      logic       power_enable;
      logic       alert_n;
      logic       night_out;
      logic       bad_battery;
      logic       watchdog_running;
      logic       alert_active;
      logic       night_only_mode;
      logic       watchdog_fired;
      logic [2:0] mode_code;
   } rsp_type;

   typedef struct packed {
      logic [14:0] power_off_mv;
      logic [14:0] power_on_mv;
      logic [14:0] bad_battery_mv;
      logic [12:0] day_restart_hyst_mv;
      logic [15:0] low_batt_charge_ticks;
      logic [15:0] warn_ticks;
      logic [15:0] low_power_ticks;
      logic [15:0] default_wd_off_ticks;
   } cfg_type;

endpackage

// File: rtl/core/blsc_regs.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// Battery load switch controller register file
// APB-style threshold and tick registers with zero-wait reads and writes.
//------------------------------------------------------------------------------
module blsc_regs
   import blsc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready,
   output cfg_type                  cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] reg_index;
   logic       wr_en;

   assign pready    = 1'b1;
   assign reg_index = paddr[4:2];
   assign wr_en     = psel & penable & pwrite & pready;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_POWER_OFF_MV:          cfg_in.power_off_mv          = pwdata[14:0];
            REG_POWER_ON_MV:           cfg_in.power_on_mv           = pwdata[14:0];
            REG_BAD_BATTERY_MV:        cfg_in.bad_battery_mv        = pwdata[14:0];
            REG_DAY_RESTART_HYST_MV:   cfg_in.day_restart_hyst_mv   = pwdata[12:0];
            REG_LOW_BATT_CHARGE_TICKS: cfg_in.low_batt_charge_ticks = pwdata[15:0];
            REG_WARN_TICKS:            cfg_in.warn_ticks            = pwdata[15:0];
            REG_LOW_POWER_TICKS:       cfg_in.low_power_ticks       = pwdata[15:0];
            REG_DEFAULT_WD_OFF_TICKS:  cfg_in.default_wd_off_ticks  = pwdata[15:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_POWER_OFF_MV:          prdata = CSR_DATA_BITS'(cfg_ff.power_off_mv);
         REG_POWER_ON_MV:           prdata = CSR_DATA_BITS'(cfg_ff.power_on_mv);
         REG_BAD_BATTERY_MV:        prdata = CSR_DATA_BITS'(cfg_ff.bad_battery_mv);
         REG_DAY_RESTART_HYST_MV:   prdata = CSR_DATA_BITS'(cfg_ff.day_restart_hyst_mv);
         REG_LOW_BATT_CHARGE_TICKS: prdata = CSR_DATA_BITS'(cfg_ff.low_batt_charge_ticks);
         REG_WARN_TICKS:            prdata = CSR_DATA_BITS'(cfg_ff.warn_ticks);
         REG_LOW_POWER_TICKS:       prdata = CSR_DATA_BITS'(cfg_ff.low_power_ticks);
         REG_DEFAULT_WD_OFF_TICKS:  prdata = CSR_DATA_BITS'(cfg_ff.default_wd_off_ticks);
         default:                   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.power_off_mv          <= RST_POWER_OFF_MV;
         cfg_ff.power_on_mv           <= RST_POWER_ON_MV;
         cfg_ff.bad_battery_mv        <= RST_BAD_BATTERY_MV;
         cfg_ff.day_restart_hyst_mv   <= RST_DAY_RESTART_HYST_MV;
         cfg_ff.low_batt_charge_ticks <= RST_LOW_BATT_CHARGE_TICKS;
         cfg_ff.warn_ticks            <= RST_WARN_TICKS;
         cfg_ff.low_power_ticks       <= RST_LOW_POWER_TICKS;
         cfg_ff.default_wd_off_ticks  <= RST_DEFAULT_WD_OFF_TICKS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: rtl/core/blsc_ctrl.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// Battery load switch controller mode logic
// Mode machine, off timer and watchdog state; builds the result word.
//------------------------------------------------------------------------------
module blsc_ctrl
   import blsc_pkg::*;
#(
   parameter int TIMER_BITS = 16
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type result
);

   mode_type              mode_ff, mode_in;
   logic [TIMER_BITS-1:0] timer_ff, timer_in;
   logic [7:0]            wd_cnt_ff, wd_cnt_in;
   logic                  wd_enable_ff, wd_enable_in;
   logic                  wd_written_ff, wd_written_in;
   logic                  wd_fired_ff, wd_fired_in;
   logic [15:0]           wd_off_ticks_ff, wd_off_ticks_in;

   logic [TIMER_BITS-1:0] lbct_t, warn_t, lpt_t, wd_off_t;
   logic [TIMER_BITS-1:0] timer_dec;
   logic                  dec_zero;
   logic [TIMER_BITS-1:0] lb_timer;
   logic [15:0]           vb;
   logic [15:0]           poff, pon, restart_mv;
   logic                  night, night_only, charging, wd_on, wd_run;
   logic                  vb_low, vb_restart, fire;

   assign lbct_t     = TIMER_BITS'(cfg.low_batt_charge_ticks);
   assign warn_t     = TIMER_BITS'(cfg.warn_ticks);
   assign lpt_t      = TIMER_BITS'(cfg.low_power_ticks);
   assign wd_off_t   = TIMER_BITS'(wd_off_ticks_ff);
   assign timer_dec  = timer_ff - TIMER_BITS'(1);
   assign dec_zero   = (timer_ff == TIMER_BITS'(1));

   assign vb         = item.battery_mv;
   assign poff       = {1'b0, cfg.power_off_mv};
   assign pon        = {1'b0, cfg.power_on_mv};
   // fits: 15-bit level plus 13-bit margin stays below 2^16
   assign restart_mv = poff + {3'b000, cfg.day_restart_hyst_mv};
   assign vb_low     = (vb <= poff);
   assign vb_restart = (vb >= restart_mv);

   assign night      = (item.charger_mode == CHG_NIGHT);
   assign charging   = (item.charger_mode == CHG_IDLE) | night;
   assign night_only = ~item.pctrl_pin;
   assign wd_on      = wd_enable_ff & wd_written_ff;
   assign fire       = wd_on & (wd_cnt_ff == 8'd1);

   // low-battery off: reload while charging, else count down; hold at zero
   assign lb_timer = (timer_ff == '0) ? timer_ff : (charging ? lbct_t : timer_dec);

   always_comb begin
      mode_in         = mode_ff;
      timer_in        = timer_ff;
      wd_cnt_in       = wd_cnt_ff;
      wd_enable_in    = wd_enable_ff;
      wd_written_in   = wd_written_ff;
      wd_fired_in     = wd_fired_ff;
      wd_off_ticks_in = wd_off_ticks_ff;
      unique case (item.op)
         OP_TICK: begin
            unique case (mode_ff)
               MODE_OFF_LB: begin
                  timer_in = lb_timer;
                  if ((vb >= pon) && (lb_timer == '0)) begin
                     mode_in = night_only ? MODE_OFF_DAY : MODE_ON;
                  end
               end
               MODE_OFF_DAY: begin
                  if (vb_low) begin
                     mode_in  = MODE_OFF_LB;
                     timer_in = lbct_t;
                  end else if (vb_restart && night) begin
                     mode_in = MODE_ON;
                  end
               end
               MODE_ALERT_LB: begin
                  timer_in = timer_dec;
                  if (dec_zero) begin
                     mode_in  = MODE_OFF_LB;
                     timer_in = lbct_t;
                  end
               end
               MODE_ALERT_DAY: begin
                  timer_in = timer_dec;
                  if (dec_zero) begin
                     mode_in = MODE_OFF_DAY;
                  end
               end
               MODE_ON: begin
                  if (wd_on && (wd_cnt_ff != 8'd0)) begin
                     wd_cnt_in = wd_cnt_ff - 8'd1;
                  end
                  if (fire) begin
                     wd_fired_in = 1'b1;
                     mode_in     = MODE_WD_ALERT;
                     timer_in    = warn_t;
                  end else if (vb_low) begin
                     timer_in = timer_dec;
                     if (dec_zero) begin
                        mode_in  = MODE_ALERT_LB;
                        timer_in = warn_t;
                     end
                  end else if (night_only && !night) begin
                     mode_in  = MODE_ALERT_DAY;
                     timer_in = warn_t;
                  end else begin
                     timer_in = lpt_t;
                  end
               end
               MODE_WD_ALERT: begin
                  if (!wd_on) begin
                     mode_in = MODE_ON;
                  end else begin
                     timer_in = timer_dec;
                     if (dec_zero) begin
                        mode_in  = MODE_WD_OFF;
                        timer_in = wd_off_t;
                     end
                  end
               end
               MODE_WD_OFF: begin
                  if (!wd_on) begin
                     mode_in = MODE_ON;
                  end else begin
                     timer_in = timer_dec;
                     if (dec_zero) begin
                        mode_in         = MODE_ON;
                        wd_enable_in    = 1'b0;
                        wd_written_in   = 1'b0;
                        wd_cnt_in       = 8'd0;
                        wd_off_ticks_in = cfg.default_wd_off_ticks;
                     end
                  end
               end
               default: begin
                  // recovery from unknown mode
                  if (!vb_low) begin
                     mode_in = MODE_ON;
                  end else begin
                     mode_in  = MODE_OFF_LB;
                     timer_in = lbct_t;
                  end
                  wd_enable_in    = 1'b0;
                  wd_written_in   = 1'b0;
                  wd_cnt_in       = 8'd0;
                  wd_off_ticks_in = cfg.default_wd_off_ticks;
               end
            endcase
         end
         OP_INIT: begin
            wd_enable_in    = 1'b0;
            wd_written_in   = 1'b0;
            wd_fired_in     = 1'b0;
            wd_cnt_in       = 8'd0;
            wd_off_ticks_in = cfg.default_wd_off_ticks;
            timer_in        = '0;
            if (vb_low) begin
               mode_in  = MODE_OFF_LB;
               timer_in = lbct_t;
            end else if (night_only && !night) begin
               mode_in = MODE_OFF_DAY;
            end else begin
               mode_in = MODE_ON;
            end
         end
         OP_WD_ENABLE: begin
            if (wd_enable_ff && (item.write_value == 16'd0)) begin
               wd_written_in   = 1'b0;
               wd_cnt_in       = 8'd0;
               wd_off_ticks_in = cfg.default_wd_off_ticks;
            end
            wd_enable_in = (item.write_value != 16'd0);
         end
         OP_WD_TIMEOUT: begin
            wd_cnt_in     = item.write_value[7:0];
            wd_written_in = (item.write_value[7:0] != 8'd0);
         end
         OP_WD_OFF_TIME: begin
            wd_off_ticks_in = (item.write_value == 16'd0) ? cfg.default_wd_off_ticks
                                                          : item.write_value;
         end
         default: begin
            mode_in = mode_ff;
         end
      endcase
   end

   // a tick reports the watchdog as sampled before it
   assign wd_run = (item.op == OP_TICK) ? wd_on : (wd_enable_in & wd_written_in);

   always_comb begin
      result.power_enable     = !((mode_in == MODE_OFF_LB) || (mode_in == MODE_OFF_DAY) ||
                                  (mode_in == MODE_WD_OFF));
      result.alert_n          = (mode_in == MODE_ON);
      result.alert_active     = (mode_in != MODE_ON);
      result.night_out        = night;
      result.bad_battery      = (vb < {1'b0, cfg.bad_battery_mv});
      result.watchdog_running = wd_run;
      result.night_only_mode  = night_only;
      result.watchdog_fired   = wd_fired_in;
      unique case (mode_in)
         MODE_ON:        result.mode_code = MODE_CODE_ON;
         MODE_ALERT_LB:  result.mode_code = MODE_CODE_ALERT_LB;
         MODE_OFF_LB:    result.mode_code = MODE_CODE_OFF_LB;
         MODE_ALERT_DAY: result.mode_code = MODE_CODE_ALERT_DAY;
         MODE_OFF_DAY:   result.mode_code = MODE_CODE_OFF_DAY;
         MODE_WD_ALERT:  result.mode_code = MODE_CODE_WD_ALERT;
         MODE_WD_OFF:    result.mode_code = MODE_CODE_WD_OFF;
         default:        result.mode_code = MODE_CODE_UNKNOWN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_UNKNOWN;
         timer_ff        <= '0;
         wd_cnt_ff       <= 8'd0;
         wd_enable_ff    <= 1'b0;
         wd_written_ff   <= 1'b0;
         wd_fired_ff     <= 1'b0;
         wd_off_ticks_ff <= RST_DEFAULT_WD_OFF_TICKS;
      end else if (advance) begin
         mode_ff         <= mode_in;
         timer_ff        <= timer_in;
         wd_cnt_ff       <= wd_cnt_in;
         wd_enable_ff    <= wd_enable_in;
         wd_written_ff   <= wd_written_in;
         wd_fired_ff     <= wd_fired_in;
         wd_off_ticks_ff <= wd_off_ticks_in;
      end
   end

endmodule

// File: rtl/core/battery_load_switch_controller.sv
`timescale 1ns / 1ps
// Path: input register, mode logic, then result register once that slot frees.
// Throughput: one word per cycle unless the result side stalls; the input
//   register refills while the result register is taken.
// Reset: synchronous, active high; mode goes unknown, timers and watchdog clear,
//   registers return to their defaults. No clearing pass.
//------------------------------------------------------------------------------
// Battery load switch controller
// Input register, mode logic and result register with an APB register port.
//------------------------------------------------------------------------------
`include "battery_load_switch_controller_defines.svh"

module battery_load_switch_controller
   import blsc_pkg::*;
#(
   parameter int TIMER_BITS = 16
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_type                  rsp_data,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   cfg_type cfg;
   req_type in_data_ff;
   logic    in_valid_ff, in_valid_in;
   rsp_type out_data_ff;
   rsp_type result;
   logic    out_valid_ff, out_valid_in;
   logic    advance;
   logic    req_fire;
   logic    rsp_stalled;
   logic    rsp_on;
   logic    rsp_known;
   logic    mode_step;

   blsc_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   blsc_ctrl #(
      .TIMER_BITS (TIMER_BITS)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_data_ff),
      .cfg     (cfg),
      .result  (result)
   );

   // move the held word into the result register when that slot frees up
   assign advance   = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;
   assign req_fire  = req_valid & req_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   assign in_valid_in  = req_fire | (in_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

   assign rsp_stalled = rsp_valid & ~rsp_ready;
   assign rsp_on      = rsp_valid & rsp_data.alert_n;
   assign rsp_known   = rsp_valid & (rsp_data.mode_code != MODE_CODE_UNKNOWN);
   assign mode_step   = advance & ((in_data_ff.op == OP_TICK) | (in_data_ff.op == OP_INIT));

   `BLSC_ASSERT_NOW(a_stall_only_on_backpressure, clock, reset, !req_ready, rsp_stalled)
   `BLSC_ASSERT_NOW(a_alert_pair, clock, reset, rsp_valid, rsp_data.alert_n ^ rsp_data.alert_active)
   `BLSC_ASSERT_NOW(a_on_is_powered, clock, reset, rsp_on, rsp_data.power_enable)
   `BLSC_ASSERT_NEXT(a_tick_leaves_unknown, clock, reset, mode_step, rsp_known)

endmodule

// File: tb/sv/battery_load_switch_controller_tb.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// Battery load switch controller testbench
// Drives operation words and register writes into the controller, predicts
// every status word from a behavioral copy of the mode, off timer and watchdog,
// and checks each returned status word field by field.
//------------------------------------------------------------------------------
module battery_load_switch_controller_tb;
   import blsc_pkg::*;

   // codes the package leaves unnamed
   localparam logic [2:0] OP_SPARE_5   = 3'd5;
   localparam logic [2:0] OP_SPARE_7   = 3'd7;
   localparam logic [1:0] CHG_CHARGING = 2'd0;
   localparam logic [1:0] CHG_SPARE    = 2'd3;

   class load_switch_scoreboard;
      cfg_type     cfg;
      logic [2:0]  mode;
      logic [15:0] off_timer;
      logic [7:0]  wd_count;
      logic        wd_enable;
      logic        wd_armed;
      logic        wd_fired;
      logic [15:0] wd_off;
      rsp_type     expected_status[$];
      int          errors;
      int          checked;

      function new();
         cfg.power_off_mv          = RST_POWER_OFF_MV;
         cfg.power_on_mv           = RST_POWER_ON_MV;
         cfg.bad_battery_mv        = RST_BAD_BATTERY_MV;
         cfg.day_restart_hyst_mv   = RST_DAY_RESTART_HYST_MV;
         cfg.low_batt_charge_ticks = RST_LOW_BATT_CHARGE_TICKS;
         cfg.warn_ticks            = RST_WARN_TICKS;
         cfg.low_power_ticks       = RST_LOW_POWER_TICKS;
         cfg.default_wd_off_ticks  = RST_DEFAULT_WD_OFF_TICKS;
         mode      = MODE_CODE_UNKNOWN;
         off_timer = '0;
         wd_count  = '0;
         wd_enable = 1'b0;
         wd_armed  = 1'b0;
         wd_fired  = 1'b0;
         wd_off    = RST_DEFAULT_WD_OFF_TICKS;
         errors    = 0;
         checked   = 0;
      endfunction

      function void set_reg(input logic [2:0] idx, input logic [31:0] value);
         case (idx)
            REG_POWER_OFF_MV:          cfg.power_off_mv          = value[14:0];
            REG_POWER_ON_MV:           cfg.power_on_mv           = value[14:0];
            REG_BAD_BATTERY_MV:        cfg.bad_battery_mv        = value[14:0];
            REG_DAY_RESTART_HYST_MV:   cfg.day_restart_hyst_mv   = value[12:0];
            REG_LOW_BATT_CHARGE_TICKS: cfg.low_batt_charge_ticks = value[15:0];
            REG_WARN_TICKS:            cfg.warn_ticks            = value[15:0];
            REG_LOW_POWER_TICKS:       cfg.low_power_ticks       = value[15:0];
            REG_DEFAULT_WD_OFF_TICKS:  cfg.default_wd_off_ticks  = value[15:0];
            default: ;
         endcase
      endfunction

      function void wd_clear();
         wd_enable = 1'b0;
         wd_armed  = 1'b0;
         wd_count  = '0;
         wd_off    = cfg.default_wd_off_ticks;
      endfunction

      function void start_recharge();
         mode      = MODE_CODE_OFF_LB;
         off_timer = cfg.low_batt_charge_ticks;
      endfunction

      function void predict_status(input req_type w);
         rsp_type     r;
         logic        night;
         logic        night_only;
         logic        wd_on;
         logic        fire;
         int unsigned restart_mv;
         night      = (w.charger_mode == CHG_NIGHT);
         night_only = !w.pctrl_pin;
         restart_mv = 32'(cfg.power_off_mv) + 32'(cfg.day_restart_hyst_mv);
         fire       = 1'b0;
         // a tick reports the watchdog as it stood before the tick
         wd_on      = wd_enable && wd_armed;
         case (w.op)
            OP_TICK: begin
               case (mode)
                  MODE_CODE_OFF_LB: begin
                     if (off_timer != 0) begin
                        if (w.charger_mode == CHG_IDLE || night)
                           off_timer = cfg.low_batt_charge_ticks;
                        else
                           off_timer = off_timer - 1'b1;
                     end
                     if (w.battery_mv >= cfg.power_on_mv && off_timer == 0)
                        mode = night_only ? MODE_CODE_OFF_DAY : MODE_CODE_ON;
                  end
                  MODE_CODE_OFF_DAY: begin
                     if (w.battery_mv <= cfg.power_off_mv)
                        start_recharge();
                     else if (w.battery_mv >= restart_mv && night)
                        mode = MODE_CODE_ON;
                  end
                  MODE_CODE_ALERT_LB: begin
                     off_timer = off_timer - 1'b1;
                     if (off_timer == 0)
                        start_recharge();
                  end
                  MODE_CODE_ALERT_DAY: begin
                     off_timer = off_timer - 1'b1;
                     if (off_timer == 0)
                        mode = MODE_CODE_OFF_DAY;
                  end
                  MODE_CODE_ON: begin
                     if (wd_on && wd_count != 0) begin
                        wd_count = wd_count - 1'b1;
                        if (wd_count == 0) begin
                           fire     = 1'b1;
                           wd_fired = 1'b1;
                        end
                     end
                     if (fire) begin
                        mode      = MODE_CODE_WD_ALERT;
                        off_timer = cfg.warn_ticks;
                     end else if (w.battery_mv <= cfg.power_off_mv) begin
                        // wraps when the timer is already zero
                        off_timer = off_timer - 1'b1;
                        if (off_timer == 0) begin
                           mode      = MODE_CODE_ALERT_LB;
                           off_timer = cfg.warn_ticks;
                        end
                     end else if (night_only && !night) begin
                        mode      = MODE_CODE_ALERT_DAY;
                        off_timer = cfg.warn_ticks;
                     end else begin
                        off_timer = cfg.low_power_ticks;
                     end
                  end
                  MODE_CODE_WD_ALERT: begin
                     if (!wd_on) begin
                        mode = MODE_CODE_ON;
                     end else begin
                        off_timer = off_timer - 1'b1;
                        if (off_timer == 0) begin
                           mode      = MODE_CODE_WD_OFF;
                           off_timer = wd_off;
                        end
                     end
                  end
                  MODE_CODE_WD_OFF: begin
                     if (!wd_on) begin
                        mode = MODE_CODE_ON;
                     end else begin
                        off_timer = off_timer - 1'b1;
                        if (off_timer == 0) begin
                           mode = MODE_CODE_ON;
                           wd_clear();
                        end
                     end
                  end
                  default: begin
                     if (w.battery_mv > cfg.power_off_mv)
                        mode = MODE_CODE_ON;
                     else
                        start_recharge();
                     wd_clear();
                  end
               endcase
            end
            OP_INIT: begin
               wd_enable = 1'b0;
               wd_armed  = 1'b0;
               wd_fired  = 1'b0;
               off_timer = '0;
               wd_count  = '0;
               wd_off    = cfg.default_wd_off_ticks;
               if (w.battery_mv <= cfg.power_off_mv)
                  start_recharge();
               else if (night_only && !night)
                  mode = MODE_CODE_OFF_DAY;
               else
                  mode = MODE_CODE_ON;
            end
            OP_WD_ENABLE: begin
               if (wd_enable && w.write_value == 0)
                  wd_clear();
               wd_enable = (w.write_value != 0);
            end
            OP_WD_TIMEOUT: begin
               wd_count = w.write_value[7:0];
               wd_armed = (wd_count != 0);
            end
            OP_WD_OFF_TIME: begin
               wd_off = (w.write_value == 0) ? cfg.default_wd_off_ticks : w.write_value;
            end
            default: ;
         endcase
         if (w.op != OP_TICK)
            wd_on = wd_enable && wd_armed;

         r.power_enable     = !(mode == MODE_CODE_OFF_LB || mode == MODE_CODE_OFF_DAY ||
                                mode == MODE_CODE_WD_OFF);
         r.alert_n          = (mode == MODE_CODE_ON);
         r.night_out        = night;
         r.bad_battery      = (w.battery_mv < cfg.bad_battery_mv);
         r.watchdog_running = wd_on;
         r.alert_active     = (mode != MODE_CODE_ON);
         r.night_only_mode  = night_only;
         r.watchdog_fired   = wd_fired;
         r.mode_code        = mode;
         expected_status.push_back(r);
      endfunction

      function void compare(input string field, input logic [2:0] exp_v,
                            input logic [2:0] act_v);
         if (act_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", field, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check_status(input rsp_type act);
         rsp_type exp_w;
         if (expected_status.size() == 0) begin
            $error("status word %h arrived with none outstanding", act);
            errors++;
            return;
         end
         exp_w = expected_status.pop_front();
         checked++;
         compare("power_enable", 3'(exp_w.power_enable), 3'(act.power_enable));
         compare("alert_n", 3'(exp_w.alert_n), 3'(act.alert_n));
         compare("night_out", 3'(exp_w.night_out), 3'(act.night_out));
         compare("bad_battery", 3'(exp_w.bad_battery), 3'(act.bad_battery));
         compare("watchdog_running", 3'(exp_w.watchdog_running), 3'(act.watchdog_running));
         compare("alert_active", 3'(exp_w.alert_active), 3'(act.alert_active));
         compare("night_only_mode", 3'(exp_w.night_only_mode), 3'(act.night_only_mode));
         compare("watchdog_fired", 3'(exp_w.watchdog_fired), 3'(act.watchdog_fired));
         compare("mode_code", exp_w.mode_code, act.mode_code);
      endfunction
   endclass

   logic                     clock;
   logic                     reset     = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   req_type                  req_data  = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   rsp_type                  rsp_data;
   logic                     psel      = 1'b0;
   logic                     penable   = 1'b0;
   logic                     pwrite    = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr     = '0;
   logic [CSR_DATA_BITS-1:0] pwdata    = '0;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   load_switch_scoreboard sb;
   bit                    steady = 1'b0;
   int                    words_sent = 0;
   int                    settings_loaded = 0;

   battery_load_switch_controller uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // result side: take status words and stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            sb.check_status(rsp_data);
         rsp_ready <= steady || ($urandom_range(0, 99) >= 20);
      end
   end

   function automatic req_type make_word(input logic [2:0] op, input logic [15:0] mv,
                                         input logic [1:0] chg, input logic pin,
                                         input logic [15:0] wv);
      req_type w;
      w.op           = op;
      w.battery_mv   = mv;
      w.charger_mode = chg;
      w.pctrl_pin    = pin;
      w.write_value  = wv;
      return w;
   endfunction

   // battery level near one of the current thresholds, or anywhere
   function automatic logic [15:0] pick_mv();
      int unsigned base;
      case ($urandom_range(0, 5))
         0: base = 32'(sb.cfg.power_off_mv);
         1: base = 32'(sb.cfg.power_on_mv);
         2: base = 32'(sb.cfg.bad_battery_mv);
         3: base = 32'(sb.cfg.power_off_mv) + 32'(sb.cfg.day_restart_hyst_mv);
         4: return 16'($urandom);
         default: return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
      endcase
      base = base + $urandom_range(0, 4);
      base = (base >= 2) ? base - 2 : 0;
      return 16'(base);
   endfunction

   task automatic send_word(input req_type w);
      while (!steady && $urandom_range(0, 99) < 20) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      sb.predict_status(w);
      words_sent++;
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_reg(idx, value);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_status.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic load_settings(input cfg_type c);
      drain();
      write_reg(REG_POWER_OFF_MV, 32'(c.power_off_mv));
      write_reg(REG_POWER_ON_MV, 32'(c.power_on_mv));
      write_reg(REG_BAD_BATTERY_MV, 32'(c.bad_battery_mv));
      write_reg(REG_DAY_RESTART_HYST_MV, 32'(c.day_restart_hyst_mv));
      write_reg(REG_LOW_BATT_CHARGE_TICKS, 32'(c.low_batt_charge_ticks));
      write_reg(REG_WARN_TICKS, 32'(c.warn_ticks));
      write_reg(REG_LOW_POWER_TICKS, 32'(c.low_power_ticks));
      write_reg(REG_DEFAULT_WD_OFF_TICKS, 32'(c.default_wd_off_ticks));
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      settings_loaded++;
   endtask

   task automatic run_random(input int n);
      int          sent;
      int          kind;
      int          len;
      logic [15:0] mv;
      logic [1:0]  chg;
      logic        pin;
      sent = 0;
      mv   = pick_mv();
      chg  = 2'($urandom_range(0, 3));
      pin  = 1'($urandom_range(0, 1));
      while (sent < n) begin
         kind = $urandom_range(0, 99);
         // hold conditions across words so the timers get to run out
         if ($urandom_range(0, 3) == 0)
            mv = pick_mv();
         if ($urandom_range(0, 3) == 0)
            chg = 2'($urandom_range(0, 3));
         if ($urandom_range(0, 7) == 0)
            pin = ~pin;
         if (kind < 40) begin
            len = $urandom_range(1, 8);
            repeat (len) send_word(make_word(OP_TICK, mv, chg, pin, 16'($urandom)));
            sent += len;
         end else if (kind < 60) begin
            // arm the watchdog, then let it run down
            send_word(make_word(OP_WD_ENABLE, mv, chg, pin,
                                16'(1 << $urandom_range(0, 15))));
            send_word(make_word(OP_WD_TIMEOUT, mv, chg, pin,
                                {8'($urandom), 8'($urandom_range(1, 5))}));
            send_word(make_word(OP_WD_OFF_TIME, mv, chg, pin,
                                16'($urandom_range(0, 4))));
            len = $urandom_range(2, 10);
            repeat (len) send_word(make_word(OP_TICK, mv, chg, pin, 16'($urandom)));
            sent += len + 3;
         end else if (kind < 68) begin
            send_word(make_word(OP_INIT, mv, chg, pin, 16'($urandom)));
            sent++;
         end else begin
            send_word(make_word(3'($urandom), $urandom_range(0, 1) ? mv : 16'($urandom),
                                2'($urandom), 1'($urandom), 16'($urandom)));
            sent++;
         end
      end
   endtask

   initial begin
      cfg_type c;
      int      phase;
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // unknown mode after reset: writes report status before any tick
      send_word(make_word(OP_SPARE_5, 16'h0000, CHG_SPARE, 1'b0, 16'hffff));
      send_word(make_word(OP_SPARE_7, 16'hffff, CHG_NIGHT, 1'b1, 16'h0000));
      send_word(make_word(OP_WD_OFF_TIME, 16'd8999, CHG_IDLE, 1'b1, 16'h0000));
      send_word(make_word(OP_WD_ENABLE, 16'd9000, CHG_CHARGING, 1'b0, 16'h8000));
      send_word(make_word(OP_WD_TIMEOUT, 16'd11500, CHG_NIGHT, 1'b1, 16'hff03));
      send_word(make_word(OP_TICK, $urandom_range(0, 1) ? 16'd11501 : 16'd11500,
                          CHG_CHARGING, 1'b1, 16'h0000));

      c.power_off_mv          = 15'd11500;
      c.power_on_mv           = 15'd12500;
      c.bad_battery_mv        = 15'd9000;
      c.day_restart_hyst_mv   = 13'd500;
      c.low_batt_charge_ticks = 16'd2;
      c.warn_ticks            = 16'd2;
      c.low_power_ticks       = 16'd1;
      c.default_wd_off_ticks  = 16'd3;
      load_settings(c);

      // watchdog fires, power-cycles the load and disarms itself
      send_word(make_word(OP_INIT, 16'd12000, CHG_NIGHT, 1'b1, 16'h0000));
      send_word(make_word(OP_WD_ENABLE, 16'd12000, CHG_NIGHT, 1'b1, 16'h0001));
      send_word(make_word(OP_WD_TIMEOUT, 16'd12000, CHG_NIGHT, 1'b1, 16'h0002));
      send_word(make_word(OP_WD_OFF_TIME, 16'd12000, CHG_NIGHT, 1'b1, 16'h0000));
      repeat (7) send_word(make_word(OP_TICK, 16'd12000, CHG_NIGHT, 1'b1, 16'h0000));
      // low battery with a cleared timer: decrement wraps
      send_word(make_word(OP_TICK, 16'd11500, CHG_CHARGING, 1'b1, 16'h0000));
      // night-only load: day off, night restart, day alert and off
      send_word(make_word(OP_INIT, 16'd12000, CHG_CHARGING, 1'b0, 16'h0000));
      send_word(make_word(OP_TICK, 16'd12000, CHG_NIGHT, 1'b0, 16'h0000));
      repeat (3) send_word(make_word(OP_TICK, 16'd13000, CHG_CHARGING, 1'b0, 16'h0000));
      // battery collapse, recharge hold and restart
      send_word(make_word(OP_TICK, 16'd100, CHG_CHARGING, 1'b1, 16'h0000));
      send_word(make_word(OP_TICK, 16'hffff, CHG_IDLE, 1'b1, 16'h0000));
      repeat (2) send_word(make_word(OP_TICK, 16'hffff, CHG_SPARE, 1'b1, 16'h0000));

      for (phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin
               c.power_off_mv          = RST_POWER_OFF_MV;
               c.power_on_mv           = RST_POWER_ON_MV;
               c.bad_battery_mv        = RST_BAD_BATTERY_MV;
               c.day_restart_hyst_mv   = RST_DAY_RESTART_HYST_MV;
               c.low_batt_charge_ticks = 16'($urandom_range(1, 4));
               c.warn_ticks            = 16'($urandom_range(1, 4));
               c.low_power_ticks       = 16'($urandom_range(1, 4));
               c.default_wd_off_ticks  = 16'($urandom_range(1, 4));
            end
            1: begin
               c.power_off_mv          = '0;
               c.power_on_mv           = '0;
               c.bad_battery_mv        = '0;
               c.day_restart_hyst_mv   = '0;
               c.low_batt_charge_ticks = 16'd1;
               c.warn_ticks            = 16'd1;
               c.low_power_ticks       = 16'd1;
               c.default_wd_off_ticks  = 16'd1;
            end
            2: begin
               c.power_off_mv          = 15'd20000;
               c.power_on_mv           = 15'd20000;
               c.bad_battery_mv        = 15'd20000;
               c.day_restart_hyst_mv   = 13'd5000;
               c.low_batt_charge_ticks = 16'hffff;
               c.warn_ticks            = 16'hffff;
               c.low_power_ticks       = 16'hffff;
               c.default_wd_off_ticks  = 16'hffff;
            end
            default: begin
               c.power_off_mv          = 15'($urandom_range(0, 20000));
               c.power_on_mv           = 15'($urandom_range(0, 20000));
               c.bad_battery_mv        = 15'($urandom_range(0, 20000));
               c.day_restart_hyst_mv   = 13'($urandom_range(0, 5000));
               c.low_batt_charge_ticks = 16'($urandom_range(1, 8 + 20 * (phase - 3)));
               c.warn_ticks            = 16'($urandom_range(1, 8 + 20 * (phase - 3)));
               c.low_power_ticks       = 16'($urandom_range(1, 8 + 20 * (phase - 3)));
               c.default_wd_off_ticks  = 16'($urandom_range(1, 8 + 20 * (phase - 3)));
            end
         endcase
         load_settings(c);
         steady <= (phase == 3);
         run_random(260);
      end

      drain();
      $display("%0d words checked as %0d status words over %0d register settings",
               words_sent, sb.checked, settings_loaded);
      $display("watchdog, low battery, day-off and unknown-mode paths exercised");
      if (sb.errors == 0 && sb.expected_status.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/blsc_pkg.sv
rtl/core/blsc_regs.sv
rtl/core/blsc_ctrl.sv
rtl/core/battery_load_switch_controller.sv
tb/sv/battery_load_switch_controller_tb.sv
